/* src/resizing_ring_deque_assert.svh */
// Assertion macros used by the deque control (rrd_ctrl).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef RESIZING_RING_DEQUE_ASSERT_SVH
`define RESIZING_RING_DEQUE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RRD_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define RRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define RRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rrd_pkg.sv */
// Package for the resizing ring deque: command and status codes,
// fixed field widths and the metadata word passed between stages.
// No dependencies.
`default_nettype none

package rrd_pkg;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int RDATA_W = 32;
    localparam int MIN_CAP = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Result fields known at command time; read data joins from the registered store read.
    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  element_count;
        logic [COUNT_W-1:0]  logical_capacity;
        logic                read_ok;
    } rrd_meta_t;

    // Element store strobes.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } rrd_mem_ctl_t;

endpackage

`default_nettype wire

/* src/rrd_store.sv */
// Element store of the deque: one write port, one registered read port.
// Depends on rrd_pkg.
`default_nettype none

module rrd_store #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire rrd_pkg::rrd_mem_ctl_t         mem_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [rrd_pkg::VALUE_W-1:0]   wr_value,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [rrd_pkg::RDATA_W-1:0]   rd_data
);
    import rrd_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Keep the pushed value to the stored width.
    assign wdata   = DATA_WIDTH'(wr_value);
    assign rd_data = RDATA_W'(rdata_reg);

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (mem_ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/rrd_ctrl.sv */
// Deque control: head pointer, count and logical capacity, command decode
// and store addressing. Depends on rrd_pkg and resizing_ring_deque_assert.svh.
`default_nettype none
`include "resizing_ring_deque_assert.svh"

module rrd_ctrl #(
    parameter int DEPTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire rrd_pkg::cmd_t                 cmd,
    input  wire logic [rrd_pkg::INDEX_W-1:0]   index,
    output rrd_pkg::rrd_mem_ctl_t              mem_ctl,
    output logic      [$clog2(DEPTH)-1:0]      wr_addr,
    output logic      [$clog2(DEPTH)-1:0]      rd_addr,
    output rrd_pkg::rrd_meta_t                 meta
);
    import rrd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cap_reg, cap_next;

    logic          full, empty, in_range;
    logic [AW-1:0] head_inc, head_dec;
    logic [CW:0]   tail_sum, tail_wrap, idx_sum, idx_wrap;
    logic [CW-1:0] count_inc, count_dec;
    logic [CW:0]   cap_dbl;
    logic [CW-1:0] cap_grow_val, cap_half, cap_shrink_val;
    logic [CW-1:0] cap_grow, cap_shrink;
    status_t       status;
    logic          read_ok;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign in_range = (IW'(index) < IW'(count_reg));

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    // Ring positions: sums stay below twice the depth, so one subtract wraps.
    assign tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= (CW + 1)'(DEPTH)) ? tail_sum - (CW + 1)'(DEPTH)
                                                      : tail_sum;
    assign idx_sum   = (CW + 1)'(head_reg) + (CW + 1)'(CW'(index));
    assign idx_wrap  = (idx_sum >= (CW + 1)'(DEPTH)) ? idx_sum - (CW + 1)'(DEPTH)
                                                     : idx_sum;

    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);

    // Double on reaching capacity, saturate at the physical depth.
    assign cap_dbl      = {cap_reg, 1'b0};
    assign cap_grow_val = (cap_dbl > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : cap_dbl[CW-1:0];
    assign cap_grow     = (count_inc == cap_reg) ? cap_grow_val : cap_reg;

    // Halve when a pop leaves a quarter, never below the floor.
    assign cap_half       = cap_reg >> 1;
    assign cap_shrink_val = (cap_half < CW'(MIN_CAP)) ? CW'(MIN_CAP) : cap_half;
    assign cap_shrink     = (count_dec == (cap_reg >> 2)) ? cap_shrink_val : cap_reg;

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        status         = ST_OK;
        read_ok        = 1'b0;
        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        wr_addr        = tail_wrap[AW-1:0];
        rd_addr        = idx_wrap[AW-1:0];
        unique case (cmd)
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mem_ctl.wr_en = fire;
                    count_next    = count_inc;
                    cap_next      = cap_grow;
                end
            end
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mem_ctl.wr_en = fire;
                    wr_addr       = head_dec;
                    head_next     = head_dec;
                    count_next    = count_inc;
                    cap_next      = cap_grow;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_dec;
                    cap_next   = cap_shrink;
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_dec;
                    cap_next   = cap_shrink;
                end
            end
            CMD_READ:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    mem_ctl.rd_en = fire;
                    read_ok       = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
                cap_next   = CW'(MIN_CAP);
            end
            default:
            begin
            end
        endcase
    end

    assign meta.status           = status;
    assign meta.element_count    = COUNT_W'(count_next);
    assign meta.logical_capacity = COUNT_W'(cap_next);
    assign meta.read_ok          = read_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CW'(MIN_CAP);
        end
        else if (fire)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    `RRD_ASSERT_HOLDS(a_count_le_cap, count_reg <= cap_reg, "count above capacity")
    `RRD_ASSERT_HOLDS(a_cap_bounds, (cap_reg >= CW'(MIN_CAP)) && (cap_reg <= CW'(DEPTH)), "capacity out of bounds")
    `RRD_ASSERT_NEXT(a_full_push_holds, fire && full && ((cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT)), $stable(count_reg) && $stable(head_reg) && $stable(cap_reg), "refused push changed state")
    `RRD_ASSERT_NEXT(a_clear_resets, fire && (cmd == CMD_CLEAR), (count_reg == '0) && (head_reg == '0) && (cap_reg == CW'(MIN_CAP)), "clear did not reset state")

endmodule

`default_nettype wire

/* src/rrd_out.sv */
// Result path: holds the command metadata while the store read completes,
// then an output register toward the result channel. Depends on rrd_pkg.
`default_nettype none

module rrd_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire rrd_pkg::rrd_meta_t            meta_in,
    input  wire logic [rrd_pkg::RDATA_W-1:0]   rd_data,
    output logic                               in_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [rrd_pkg::RDATA_W-1:0]   out_data,
    output rrd_pkg::rrd_meta_t                 out_meta
);
    import rrd_pkg::*;

    logic               s1_valid_reg;
    rrd_meta_t          s1_meta_reg;
    logic               out_valid_reg;
    rrd_meta_t          out_meta_reg;
    logic [RDATA_W-1:0] out_data_reg;
    logic               s1_move;

    // Advance the held word whenever the output register is free or drains.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_meta_reg <= meta_in;
        end
        if (s1_move)
        begin
            out_meta_reg <= s1_meta_reg;
            out_data_reg <= s1_meta_reg.read_ok ? rd_data : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_meta  = out_meta_reg;

endmodule

`default_nettype wire

/* src/resizing_ring_deque.sv */
// Top level of the resizing ring deque: stream ports, control, store and
// result path. Depends on rrd_pkg, rrd_ctrl, rrd_store and rrd_out.
//
//   channel  | direction | carries                    | accepted when
//   ---------+-----------+----------------------------+------------------------------
//   s_axis   | in        | command, value, index      | s_axis_tvalid && s_axis_tready
//   m_axis   | out       | read_data, status, count,  | m_axis_tvalid && m_axis_tready
//            |           | logical_capacity           |
//
// One word is accepted per clock while s_axis_tready is high; each produces exactly one result word.
// Between accept and result valid lie the metadata stage, which waits on the registered
// read port of the element store, and then the output register.
// rst_n clears head, count, capacity (to 2) and all valid flags; the element
// store is not cleared and needs no clearing pass after reset.
// A stall on m_axis holds the output register; one more word is absorbed in
// the stage behind it before s_axis_tready drops.
`default_nettype none

module resizing_ring_deque #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] value, [41:32] index, [47:42] zero fill
    input  wire logic [47:0] s_axis_tdata,
    // [2:0] command
    input  wire logic [2:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] read_data, [42:32] element_count, [53:43] logical_capacity,
    // [55:54] zero fill
    output logic      [55:0] m_axis_tdata,
    // [1:0] status
    output logic      [1:0]  m_axis_tuser
);
    import rrd_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               fire;
    cmd_t               cmd;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;

    rrd_mem_ctl_t       mem_ctl;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    rrd_meta_t          meta;
    logic [RDATA_W-1:0] rd_data;
    logic [RDATA_W-1:0] out_data;
    rrd_meta_t          out_meta;

    // Unpack the command word.
    assign cmd   = cmd_t'(s_axis_tuser);
    assign value = s_axis_tdata[VALUE_W-1:0];
    assign index = s_axis_tdata[VALUE_W +: INDEX_W];
    assign fire  = s_axis_tvalid && s_axis_tready;

    // Decode the command and update head, count and capacity on accept.
    rrd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .cmd     (cmd),
        .index   (index),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .meta    (meta)
    );

    // Write pushes and read lookups in the same edge as the accept.
    rrd_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk      (clk),
        .mem_ctl  (mem_ctl),
        .wr_addr  (wr_addr),
        .wr_value (value),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Join metadata with the read data and hold the result for the sink.
    rrd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .meta_in   (meta),
        .rd_data   (rd_data),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data),
        .out_meta  (out_meta)
    );

    // Pack the result word.
    assign m_axis_tdata = {2'b00, out_meta.logical_capacity, out_meta.element_count, out_data};
    assign m_axis_tuser = out_meta.status;

endmodule

`default_nettype wire

/* tb/resizing_ring_deque_tb.sv */
// Self-checking testbench for resizing_ring_deque: directed table, then random
// command traffic under varied sender idling and receiver stalls.
// Depends on rrd_pkg and the resizing_ring_deque RTL.
module resizing_ring_deque_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    localparam int DEPTH = 1024;

    // Codes the block leaves unused; they must answer OK and change nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } deque_cmd_t;

    typedef struct packed {
        logic [RDATA_W-1:0] read_data;
        status_t            status;
        logic [COUNT_W-1:0] element_count;
        logic [COUNT_W-1:0] logical_capacity;
    } deque_result_t;

    typedef struct {
        deque_cmd_t    word;
        bit            typed;
        deque_result_t answer;
    } directed_row_t;

    typedef enum int {MIX_TRAFFIC, FILL_TRAFFIC, DRAIN_TRAFFIC} traffic_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Shadow deque: same ring placement as the block, capacity kept as int so
    // that doubling past DEPTH does not wrap.
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int                 shadow_head  = 0;
    int                 shadow_count = 0;
    int                 shadow_cap   = MIN_CAP;

    deque_result_t pending_results [$];
    directed_row_t directed_rows [$];
    int            error_count   = 0;
    int            send_idle_pct = 0;
    int            stall_pct     = 0;

    resizing_ring_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock, first rising edge at 4 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Apply one command to the shadow deque and return the word it answers.
    function automatic deque_result_t deque_step(input deque_cmd_t w);
        deque_result_t r;
        int            slot;
        r.read_data = '0;
        r.status    = ST_OK;
        case (w.command)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (w.command == CMD_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        slot        = shadow_head;
                    end
                    else
                    begin
                        slot = (shadow_head + shadow_count) % DEPTH;
                    end
                    shadow_store[slot] = w.value;
                    shadow_count++;
                    // Grow when the count reaches capacity, saturating at DEPTH.
                    if (shadow_count == shadow_cap)
                        shadow_cap = (2 * shadow_cap > DEPTH) ? DEPTH : 2 * shadow_cap;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if (w.command == CMD_POP_FRONT)
                        shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    // Shrink at a quarter full, never below the floor.
                    if (shadow_count == shadow_cap / 4)
                        shadow_cap = (shadow_cap / 2 < MIN_CAP) ? MIN_CAP : shadow_cap / 2;
                end
            end
            CMD_READ:
            begin
                if (w.index >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_data = shadow_store[(shadow_head + w.index) % DEPTH];
            end
            CMD_CLEAR:
            begin
                shadow_head  = 0;
                shadow_count = 0;
                shadow_cap   = MIN_CAP;
            end
            default: ;
        endcase
        r.element_count    = shadow_count[COUNT_W-1:0];
        r.logical_capacity = shadow_cap[COUNT_W-1:0];
        return r;
    endfunction

    // Pick the next random command; reads mostly land inside the live range.
    function automatic deque_cmd_t next_word(input traffic_t mode);
        deque_cmd_t w;
        int         pick;
        pick = $urandom_range(99);
        case ($urandom_range(7))
            0:       w.value = '0;
            1:       w.value = '1;
            default: w.value = $urandom;
        endcase
        if (shadow_count > 0 && $urandom_range(9) < 8)
            w.index = INDEX_W'($urandom_range(shadow_count - 1));
        else
            w.index = INDEX_W'($urandom_range(1023));
        case (mode)
            FILL_TRAFFIC:
            begin
                // Once full, keep hammering with pushes to see them refused.
                if (pick < ((shadow_count < DEPTH) ? 97 : 50))
                    w.command = ($urandom_range(1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                else
                    w.command = CMD_READ;
            end
            DRAIN_TRAFFIC:
            begin
                if (pick < 97)
                    w.command = ($urandom_range(1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
                else if (pick < 99)
                    w.command = CMD_READ;
                else
                    w.command = ($urandom_range(1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end
            default:
            begin
                if (pick < 20)
                    w.command = CMD_PUSH_BACK;
                else if (pick < 40)
                    w.command = CMD_PUSH_FRONT;
                else if (pick < 55)
                    w.command = CMD_POP_BACK;
                else if (pick < 70)
                    w.command = CMD_POP_FRONT;
                else if (pick < 92)
                    w.command = CMD_READ;
                else if (pick < 95)
                    w.command = CMD_CLEAR;
                else
                    w.command = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end
        endcase
        return w;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                           input logic [INDEX_W-1:0] index, input bit typed,
                           input status_t st, input int cnt, input int cap);
        directed_row_t row;
        row.word.command            = cmd;
        row.word.value              = value;
        row.word.index              = index;
        row.typed                   = typed;
        row.answer.read_data        = '0;
        row.answer.status           = st;
        row.answer.element_count    = cnt[COUNT_W-1:0];
        row.answer.logical_capacity = cap[COUNT_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Present one word from a falling edge, hold it until accepted, then
    // queue its answer. Returns at the falling edge after acceptance.
    task automatic send_word(input deque_cmd_t w, input bit typed,
                             input deque_result_t answer);
        deque_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, w.index, w.value};
        s_axis_tuser  <= w.command;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // Always advance the shadow state; typed rows override its answer.
        predicted = deque_step(w);
        pending_results.push_back(typed ? answer : predicted);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every outstanding answer has come back.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] expected_val,
                               input logic [31:0] actual_val);
        if (expected_val !== actual_val)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expected_val, actual_val);
            error_count++;
        end
    endtask

    // Receiver: random backpressure at the rate of the current phase.
    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Result checker: compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, actual data 0x%0h status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_data", want.read_data, m_axis_tdata[31:0]);
                check_field("status", want.status, m_axis_tuser);
                check_field("element_count", want.element_count, m_axis_tdata[42:32]);
                check_field("logical_capacity", want.logical_capacity, m_axis_tdata[53:43]);
            end
        end
    end

    initial
    begin : stimulus
        int extra;
        int n;

        // Directed table. Typed answers only for reset state, refusals,
        // clear and the spare codes; everything else goes through the shadow.
        add_row(CMD_POP_BACK,   32'h0,        10'd0,    1, ST_EMPTY, 0, 2);
        add_row(CMD_POP_FRONT,  32'h0,        10'd0,    1, ST_EMPTY, 0, 2);
        add_row(CMD_READ,       32'h0,        10'd0,    1, ST_RANGE, 0, 2);
        add_row(CMD_READ,       32'h0,        10'd1023, 1, ST_RANGE, 0, 2);
        add_row(CMD_SPARE_LO,   32'hFFFFFFFF, 10'd1023, 1, ST_OK,    0, 2);
        add_row(CMD_SPARE_HI,   32'h0,        10'd0,    1, ST_OK,    0, 2);
        add_row(CMD_PUSH_BACK,  32'hFFFFFFFF, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_PUSH_FRONT, 32'h00000000, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_PUSH_BACK,  32'hA5A5A5A5, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_PUSH_FRONT, 32'h5A5A5A5A, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_READ,       32'h0,        10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_READ,       32'h0,        10'd3,    0, ST_OK,    0, 0);
        add_row(CMD_READ,       32'h0,        10'd4,    1, ST_RANGE, 4, 8);
        add_row(CMD_POP_BACK,   32'h0,        10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_POP_FRONT,  32'h0,        10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_POP_BACK,   32'h0,        10'd0,    0, ST_OK,    0, 0);
        // Last pop: capacity floor holds at 2.
        add_row(CMD_POP_FRONT,  32'h0,        10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_POP_FRONT,  32'h0,        10'd0,    1, ST_EMPTY, 0, 2);
        // Push at the front from an empty ring wraps the head below zero.
        add_row(CMD_PUSH_FRONT, 32'h00000001, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_PUSH_FRONT, 32'h80000000, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_READ,       32'h0,        10'd1,    0, ST_OK,    0, 0);
        add_row(CMD_CLEAR,      32'h0,        10'd0,    1, ST_OK,    0, 2);
        add_row(CMD_READ,       32'h0,        10'd0,    1, ST_RANGE, 0, 2);
        add_row(CMD_PUSH_BACK,  32'h12345678, 10'd0,    0, ST_OK,    0, 0);
        add_row(CMD_READ,       32'h0,        10'd0,    0, ST_OK,    0, 0);

        // Hold reset, then release it on a falling edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].answer);

        // Mixed traffic with no idling on either side.
        for (n = 0; n < 50; n++)
            send_word(next_word(MIX_TRAFFIC), 0, '0);
        hold_until_drained();

        // Fill to the ceiling with a mostly idle sender, then keep pushing
        // into the full store for a while.
        send_idle_pct = 75;
        extra = 0;
        while (extra < 20)
        begin
            send_word(next_word(FILL_TRAFFIC), 0, '0);
            if (shadow_count == DEPTH)
                extra++;
        end
        hold_until_drained();

        // Drain past the first halving with a stalling receiver.
        send_idle_pct = 0;
        stall_pct     = 75;
        while (shadow_count >= 256)
            send_word(next_word(DRAIN_TRAFFIC), 0, '0);

        // Mixed traffic with both sides idling now and then.
        send_idle_pct = 23;
        stall_pct     = 23;
        for (n = 0; n < 50; n++)
            send_word(next_word(MIX_TRAFFIC), 0, '0);

        // Flush: wait out the pipeline with a steady receiver.
        stall_pct = 0;
        hold_until_drained();
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("resizing_ring_deque test passed");
        else
            $display("resizing_ring_deque test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("resizing_ring_deque test failed");
        $finish;
    end

endmodule
